[rtl/natural_log_atanh_series_defines.svh]
// ----------------------------------------------------------------------------
// natural_log_atanh_series_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef NATURAL_LOG_ATANH_SERIES_DEFINES_SVH
`define NATURAL_LOG_ATANH_SERIES_DEFINES_SVH

// checked only out of reset
`define NLOG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define NLOG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/nlog_pkg.sv]
// ----------------------------------------------------------------------------
// nlog_pkg
// shared types, widths and constants of the natural log pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nlog_pkg;

  localparam int FRAC_BITS_DEF    = 24;
  localparam int SERIES_TERMS_DEF = 5;
  localparam int MAX_TERMS        = 8;

  localparam int MANT_W   = 24;
  localparam int DEN_W    = 25;
  localparam int REM_W    = 25;
  localparam int Z_W      = 32;
  localparam int DIV_STEP = 4;
  localparam int EXP_W    = 9;
  localparam int ACC_W    = 33;
  localparam int TOT_W    = 58;
  localparam int LN2_W    = 48;
  localparam int RECIP_W  = 35;
  localparam int RECIP_SH = 34;
  localparam int DIV_W    = 4;
  localparam int LZ_W     = 5;

  localparam logic [MANT_W-1:0] HIDDEN  = 24'h80_0000;
  localparam logic [LN2_W-1:0]  LN2_Q48 = 48'hB172_17F7_D1CF;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ZERO    = 2'd1;
  localparam logic [1:0] ERR_NEG     = 2'd2;
  localparam logic [1:0] ERR_INF_NAN = 2'd3;

  // odd divisors of the series terms and their scaled reciprocals
  localparam logic [DIV_W-1:0] TERM_DIV [MAX_TERMS] = '{
    4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13, 4'd15
  };
  localparam logic [RECIP_W-1:0] RECIP [MAX_TERMS] = '{
    35'd17179869184, 35'd5726623061, 35'd3435973836, 35'd2454267026,
    35'd1908874353, 35'd1561806289, 35'd1321528398, 35'd1145324612
  };

  typedef struct packed {
    logic signed [EXP_W-1:0] expo;
    logic [1:0]              err;
  } side_t;

  // fix an estimate that may be one below floor(pv / d)
  function automatic logic [Z_W-1:0] term_fix(input logic [Z_W-1:0] q0,
                                                input logic [Z_W-1:0] pv,
                                                input logic [2:0] k);
    logic [Z_W+DIV_W-1:0] qd;
    logic [Z_W+DIV_W-1:0] rem;
    qd  = (Z_W+DIV_W)'(q0) * (Z_W+DIV_W)'(TERM_DIV[k]);
    rem = (Z_W+DIV_W)'(pv) - qd;
    if (rem >= (Z_W+DIV_W)'(TERM_DIV[k])) begin
      return q0 + Z_W'(1);
    end
    return q0;
  endfunction

endpackage

[rtl/nlog_div.sv]
// ----------------------------------------------------------------------------
// nlog_div
// pipelined restoring divider for z = (m-1)/(m+1), DIV_STEP quotient bits a stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlog_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [nlog_pkg::MANT_W-1:0] in_mant,
  input  nlog_pkg::side_t             in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [nlog_pkg::Z_W-1:0]    out_z,
  output nlog_pkg::side_t             out_side
);
  import nlog_pkg::*;

  localparam int NST = Z_W / DIV_STEP;

  logic [NST-1:0]   v;
  logic [NST:0]     en;
  logic [REM_W-1:0] rem  [NST];
  logic [Z_W-1:0]   quo  [NST];
  logic [DEN_W-1:0] den  [NST];
  side_t            side [NST];

  assign en[NST] = out_ready;

  for (genvar i = 0; i < NST; i++) begin : g_st
    logic             v_in;
    logic [REM_W-1:0] r_in;
    logic [Z_W-1:0]   q_in;
    logic [DEN_W-1:0] d_in;
    side_t            s_in;
    logic [REM_W-1:0] r_next;
    logic [Z_W-1:0]   q_next;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = REM_W'(in_mant[MANT_W-2:0]);
      assign q_in = '0;
      assign d_in = DEN_W'(in_mant) + DEN_W'(HIDDEN);
      assign s_in = in_side;
    end else begin : g_rest
      assign v_in = v[i-1];
      assign r_in = rem[i-1];
      assign q_in = quo[i-1];
      assign d_in = den[i-1];
      assign s_in = side[i-1];
    end

    assign en[i] = !v[i] || en[i+1];

    always_comb begin
      logic [REM_W:0] t;
      r_next = r_in;
      q_next = q_in;
      for (int k = 0; k < DIV_STEP; k++) begin
        t = {r_next, 1'b0};
        if (t >= (REM_W+1)'(d_in)) begin
          r_next = REM_W'(t - (REM_W+1)'(d_in));
          q_next = {q_next[Z_W-2:0], 1'b1};
        end else begin
          r_next = REM_W'(t);
          q_next = {q_next[Z_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        rem[i]  <= r_next;
        quo[i]  <= q_next;
        den[i]  <= d_in;
        side[i] <= s_in;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[NST-1];
  assign out_z     = quo[NST-1];
  assign out_side  = side[NST-1];

endmodule

[rtl/nlog_series.sv]
// ----------------------------------------------------------------------------
// nlog_series
// pipelined odd power series, sum of z^(2k+1)/(2k+1) over SERIES_TERMS terms
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlog_series #(
  parameter int SERIES_TERMS = nlog_pkg::SERIES_TERMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [nlog_pkg::Z_W-1:0]   in_z,
  input  nlog_pkg::side_t            in_side,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [nlog_pkg::ACC_W-1:0] out_sum,
  output nlog_pkg::side_t            out_side
);
  import nlog_pkg::*;

  localparam int N = SERIES_TERMS;

  logic [N+1:0]     v;
  logic [N+2:0]     en;
  logic [Z_W-1:0]   pw   [N];
  logic [Z_W-1:0]   z2   [N];
  logic [Z_W-1:0]   q    [1:N];
  logic [Z_W-1:0]   p    [1:N];
  logic [ACC_W-1:0] acc  [2:N+1];
  side_t            side [N+2];

  assign en[N+2] = out_ready;

  for (genvar s = 0; s <= N + 1; s++) begin : g_st
    logic  v_in;
    side_t s_in;

    if (s == 0) begin : g_first
      assign v_in = in_valid;
      assign s_in = in_side;
    end else begin : g_rest
      assign v_in = v[s-1];
      assign s_in = side[s-1];
    end

    assign en[s] = !v[s] || en[s+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else if (en[s]) begin
        v[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        side[s] <= s_in;
      end
    end

    if (s == 0) begin : g_sq
      logic [2*Z_W-1:0] sq;
      assign sq = (2*Z_W)'(in_z) * (2*Z_W)'(in_z);
      always_ff @(posedge clk) begin
        if (en[s]) begin
          pw[0] <= in_z;
          z2[0] <= sq[2*Z_W-1:Z_W];
        end
      end
    end

    if (s >= 1 && s <= N - 1) begin : g_pow
      logic [2*Z_W-1:0] pr;
      assign pr = (2*Z_W)'(pw[s-1]) * (2*Z_W)'(z2[s-1]);
      always_ff @(posedge clk) begin
        if (en[s]) begin
          pw[s] <= pr[2*Z_W-1:Z_W];
          z2[s] <= z2[s-1];
        end
      end
    end

    if (s >= 1 && s <= N) begin : g_quo
      logic [Z_W+RECIP_W-1:0] pr;
      assign pr = (Z_W+RECIP_W)'(pw[s-1]) * (Z_W+RECIP_W)'(RECIP[3'(s-1)]);
      always_ff @(posedge clk) begin
        if (en[s]) begin
          q[s] <= pr[Z_W+RECIP_SH-1:RECIP_SH];
          p[s] <= pw[s-1];
        end
      end
    end

    if (s == 2) begin : g_acc0
      always_ff @(posedge clk) begin
        if (en[s]) begin
          acc[s] <= ACC_W'(term_fix(q[s-1], p[s-1], 3'(s-2)));
        end
      end
    end else if (s > 2) begin : g_acc
      always_ff @(posedge clk) begin
        if (en[s]) begin
          acc[s] <= acc[s-1] + ACC_W'(term_fix(q[s-1], p[s-1], 3'(s-2)));
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[N+1];
  assign out_sum   = acc[N+1];
  assign out_side  = side[N+1];

endmodule

[rtl/natural_log_atanh_series.sv]
// ----------------------------------------------------------------------------
// natural_log_atanh_series
// natural log of a binary32 value as signed fixed point, atanh series form
//
//   channel | dir | tdata                 | tuser
//   s_      | in  | [31:0] float_bits     | -
//   m_      | out | [31:0] log_value      | [1:0] input_error
//
// one transaction per cycle while m_ is not stalled; pipeline stages are
// decode 2, divider 8, series SERIES_TERMS + 2, final combine 4
// rst clears all stage valid bits; no result is in flight after reset
// each stage holds when it is full and the next one is stalled, so a
// stall on m_ only backs up as far as the pipeline is full
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module natural_log_atanh_series #(
  parameter int FRAC_BITS    = nlog_pkg::FRAC_BITS_DEF,
  parameter int SERIES_TERMS = nlog_pkg::SERIES_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] float_bits
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] log_value
  output logic [1:0]  m_tuser    // [1:0] input_error
);
  import nlog_pkg::*;

  localparam int SH = 48 - FRAC_BITS;

  // decode stage
  logic            v_d1, en_d1;
  logic [22:0]     frac_d1;
  logic [7:0]      bexp_d1;
  logic [LZ_W-1:0] lz_d1;
  logic [1:0]      err_d1;
  logic [LZ_W-1:0] lz_next;
  logic [1:0]      err_next;

  // normalize stage
  logic              v_d2, en_d2;
  logic [MANT_W-1:0] mant_d2;
  side_t             side_d2;
  logic [MANT_W-1:0] mant_next;
  side_t             side_next;

  logic         div_in_ready, div_out_valid, ser_in_ready;
  logic [Z_W-1:0] div_z;
  side_t        div_side;
  logic         ser_out_valid;
  logic [ACC_W-1:0] ser_sum;
  side_t        ser_side;

  // final combine stages
  logic                    v_f1, v_f2, v_f3, v_f4;
  logic                    en_f1, en_f2, en_f3, en_f4;
  logic [ACC_W-1:0]        acc_f1;
  logic signed [TOT_W-1:0] prod_f1, prod_next;
  logic [1:0]              err_f1, err_f2, err_f3;
  logic signed [TOT_W-1:0] total_f2;
  logic [TOT_W-1:0]        mag_f3;
  logic                    neg_f3;
  logic signed [TOT_W-1:0] ex_w, ln_w;
  logic [TOT_W-1:0]        rnd_sum;
  logic [63:0]             r_ext;
  logic [31:0]             log_next;

  assign en_f4 = !v_f4 || m_tready;
  assign en_f3 = !v_f3 || en_f4;
  assign en_f2 = !v_f2 || en_f3;
  assign en_f1 = !v_f1 || en_f2;
  assign en_d2 = !v_d2 || div_in_ready;
  assign en_d1 = !v_d1 || en_d2;
  assign s_tready = en_d1;
  assign m_tvalid = v_f4;

  always_comb begin
    lz_next = '0;
    for (int b = 0; b < 23; b++) begin
      if (s_tdata[b]) begin
        lz_next = LZ_W'(22 - b);
      end
    end
    if (s_tdata[30:23] == 8'hFF) begin
      err_next = ERR_INF_NAN;
    end else if (s_tdata[30:0] == 31'd0) begin
      err_next = ERR_ZERO;
    end else if (s_tdata[31]) begin
      err_next = ERR_NEG;
    end else begin
      err_next = ERR_NONE;
    end
  end

  always_comb begin
    side_next.err = err_d1;
    if (bexp_d1 == 8'd0) begin
      mant_next      = MANT_W'({1'b0, frac_d1}) << (lz_d1 + LZ_W'(1));
      side_next.expo = -9'sd127 - $signed({4'b0000, lz_d1});
    end else begin
      mant_next      = {1'b1, frac_d1};
      side_next.expo = $signed({1'b0, bexp_d1}) - 9'sd127;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_d1 <= 1'b0;
      v_d2 <= 1'b0;
    end else begin
      if (en_d1) begin
        v_d1 <= s_tvalid;
      end
      if (en_d2) begin
        v_d2 <= v_d1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_d1) begin
      frac_d1 <= s_tdata[22:0];
      bexp_d1 <= s_tdata[30:23];
      lz_d1   <= lz_next;
      err_d1  <= err_next;
    end
    if (en_d2) begin
      mant_d2 <= mant_next;
      side_d2 <= side_next;
    end
  end

  nlog_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v_d2),
    .in_ready  (div_in_ready),
    .in_mant   (mant_d2),
    .in_side   (side_d2),
    .out_valid (div_out_valid),
    .out_ready (ser_in_ready),
    .out_z     (div_z),
    .out_side  (div_side)
  );

  nlog_series #(
    .SERIES_TERMS (SERIES_TERMS)
  ) u_series (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_out_valid),
    .in_ready  (ser_in_ready),
    .in_z      (div_z),
    .in_side   (div_side),
    .out_valid (ser_out_valid),
    .out_ready (en_f1),
    .out_sum   (ser_sum),
    .out_side  (ser_side)
  );

  always_comb begin
    ex_w      = TOT_W'(ser_side.expo);
    ln_w      = TOT_W'(LN2_Q48);
    prod_next = ex_w * ln_w;
    rnd_sum   = mag_f3 + (TOT_W'(1) << (SH - 1));
    r_ext     = 64'(rnd_sum) >> SH;
    if (err_f3 != ERR_NONE) begin
      log_next = '0;
    end else if (r_ext[63:31] != '0) begin
      log_next = neg_f3 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (neg_f3) begin
      log_next = -r_ext[31:0];
    end else begin
      log_next = r_ext[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f1 <= 1'b0;
      v_f2 <= 1'b0;
      v_f3 <= 1'b0;
      v_f4 <= 1'b0;
    end else begin
      if (en_f1) begin
        v_f1 <= ser_out_valid;
      end
      if (en_f2) begin
        v_f2 <= v_f1;
      end
      if (en_f3) begin
        v_f3 <= v_f2;
      end
      if (en_f4) begin
        v_f4 <= v_f3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_f1) begin
      acc_f1  <= ser_sum;
      prod_f1 <= prod_next;
      err_f1  <= ser_side.err;
    end
    if (en_f2) begin
      total_f2 <= $signed(TOT_W'(acc_f1) << 17) + prod_f1;
      err_f2   <= err_f1;
    end
    if (en_f3) begin
      neg_f3 <= total_f2[TOT_W-1];
      mag_f3 <= total_f2[TOT_W-1] ? TOT_W'(-total_f2) : TOT_W'(total_f2);
      err_f3 <= err_f2;
    end
    if (en_f4) begin
      m_tdata <= log_next;
      m_tuser <= err_f3;
    end
  end

endmodule

[rtl/nlog_chk.sv]
// ----------------------------------------------------------------------------
// nlog_chk
// port level checks of the natural log pipeline, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "natural_log_atanh_series_defines.svh"

module nlog_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);
  import nlog_pkg::*;

  `NLOG_ASSERT_RST(a_reset_empty, rst |=> !m_tvalid, "result valid right after reset")
  `NLOG_ASSERT(a_err_zero, m_tvalid && m_tuser != ERR_NONE |-> m_tdata == 32'd0, "nonzero log with error")
  `NLOG_ASSERT(a_ready_empty, !s_tready |-> m_tvalid, "input held off with empty output")
  `NLOG_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind natural_log_atanh_series nlog_chk u_chk (.*);

[dv/nlog_checker.sv]
// ----------------------------------------------------------------------------
// nlog_checker
// watches both channels of the natural log block, computes the expected
// log value and error code of every accepted input and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nlog_checker #(
  parameter int FRAC_BITS    = nlog_pkg::FRAC_BITS_DEF,
  parameter int SERIES_TERMS = nlog_pkg::SERIES_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  output int          errors,
  output int          pending
);
  import nlog_pkg::*;

  typedef struct packed {
    logic [31:0] log_value;
    logic [1:0]  err;
  } log_result_t;

  log_result_t expected_logs[$];

  function automatic logic [31:0] series_log(logic [23:0] mant, int expo);
    logic [63:0] z, z2, pw, acc, mag, r;
    logic signed [63:0] total;
    int sh;
    sh = 48 - FRAC_BITS;
    z = ({40'd0, mant - HIDDEN} << 32) / ({40'd0, mant} + 64'h80_0000);
    z2 = (z * z) >> 32;
    pw = z;
    acc = 0;
    for (int k = 0; k < SERIES_TERMS; k++) begin
      acc += pw / (2 * k + 1);
      pw = (pw * z2) >> 32;
    end
    acc <<= 1;
    total = $signed(acc << 16) + 64'(expo) * $signed({16'd0, LN2_Q48});
    mag = total < 0 ? -total : total;
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    if (total < 0) return r >= 64'h8000_0000 ? 32'h8000_0000 : 32'(-r);
    return r > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : r[31:0];
  endfunction

  function automatic log_result_t predict_log(logic [31:0] bits);
    log_result_t res;
    logic [23:0] mant;
    int expo;
    res = '0;
    if (bits[30:23] == 8'hFF) res.err = ERR_INF_NAN;
    else if (bits[30:0] == 0) res.err = ERR_ZERO;
    else if (bits[31]) res.err = ERR_NEG;
    else begin
      if (bits[30:23] == 0) begin
        mant = {1'b0, bits[22:0]};
        expo = -126;
        while (!mant[23]) begin
          mant <<= 1;
          expo--;
        end
      end else begin
        mant = {1'b1, bits[22:0]};
        expo = int'(bits[30:23]) - 127;
      end
      res.log_value = series_log(mant, expo);
      res.err = ERR_NONE;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    log_result_t exp_r;
    if (rst) begin
      errors <= 0;
    end else begin
      if (s_tvalid && s_tready) expected_logs.push_back(predict_log(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_logs.size() == 0) begin
          $display("%0t: unexpected result log %h err %0d", $time, m_tdata, m_tuser);
          errors <= errors + 1;
        end else begin
          exp_r = expected_logs.pop_front();
          if (exp_r.log_value !== m_tdata || exp_r.err !== m_tuser) begin
            $display("%0t: mismatch expected log %h err %0d, actual log %h err %0d",
                     $time, exp_r.log_value, exp_r.err, m_tdata, m_tuser);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  assign pending = expected_logs.size();

endmodule

[dv/tb_natural_log_atanh_series.sv]
// ----------------------------------------------------------------------------
// tb_natural_log_atanh_series
// drives directed and random binary32 patterns through the natural log
// block under several idle and stall mixes, including one long output stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_natural_log_atanh_series;
  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  int          errors, pending;
  int          send_idle = 0, stall_pct = 0;
  bit          hold_off = 0;
  int          cycles = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  natural_log_atanh_series u_top (.*);
  nlog_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk) m_tready <= !rst && !hold_off && ($urandom_range(99) >= stall_pct);

  function automatic logic [31:0] random_float();
    case ($urandom_range(9))
      0: return $urandom;
      1: return {1'b0, 8'd0, 23'($urandom) >> $urandom_range(22)};
      2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
      3: return {1'b1, 31'($urandom)};
      4: return {1'($urandom_range(1)), 31'd0};
      5: return {1'b0, 8'($urandom_range(120, 134)), 23'($urandom)};
      default: return {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_float(logic [31:0] bits);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= bits;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  logic [31:0] directed_floats[] = '{
    32'h3F80_0000, 32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFFFF_FFFF, 32'hBF80_0000, 32'h0000_0001, 32'h007F_FFFF,
    32'h0080_0000, 32'h7F7F_FFFF, 32'h3FFF_FFFF, 32'h3F80_0001, 32'h4000_0000,
    32'h402D_F854, 32'h3F00_0000, 32'h0040_0000, 32'h8000_0001, 32'h5555_5555,
    32'h2AAA_AAAA
  };

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (directed_floats[i]) send_float(directed_floats[i]);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 49 : 31) : 0;
      stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 49 : 31) : 0;
      if (ph == 0) begin
        fork
          begin
            hold_off = 1;
            repeat (200) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      repeat (260) send_float(random_float());
    end
    s_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

[natural_log_atanh_series.f]
+incdir+rtl
rtl/nlog_pkg.sv
rtl/nlog_div.sv
rtl/nlog_series.sv
rtl/natural_log_atanh_series.sv
rtl/nlog_chk.sv
dv/nlog_checker.sv
dv/tb_natural_log_atanh_series.sv
